FILE: hdl/dilv_pkg.sv
// shared types and constants of the decimal integer list validator
package dilv_pkg;

  localparam int MAX_COUNT = 512;
  localparam int CH_W      = 8;
  localparam int VAL_W     = 32;
  localparam int COUNT_W   = 10;
  localparam int CNT_W     = $clog2(MAX_COUNT + 1);
  localparam int ADDR_W    = $clog2(MAX_COUNT);
  localparam int MAG_W     = VAL_W + 4;

  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(1) << (VAL_W - 1);
  localparam logic [MAG_W-1:0] POS_LIM = NEG_LIM - MAG_W'(1);

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2b;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_BAD    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_DUP     = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic {
    CTL_SCAN   = 1'b0,
    CTL_SEARCH = 1'b1
  } ctl_state_e;

  typedef struct packed {
    logic accept;
    logic search;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic needs_out;
    logic to_search;
    logic search_done;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/dilv_in_if.sv
// input channel: one character or end-of-list mark per item
interface dilv_in_if;
  logic                         valid;
  logic                         ready;
  logic [dilv_pkg::CH_W-1:0]    ch;
  logic                         end_list;

  modport source (output valid, output ch, output end_list, input ready);
  modport sink   (input valid, input ch, input end_list, output ready);
endinterface

FILE: hdl/dilv_out_if.sv
// output channel: token result or list summary per item
interface dilv_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [dilv_pkg::VAL_W-1:0] token_value;
  logic [1:0]                       status;
  logic                             is_summary;
  logic [dilv_pkg::COUNT_W-1:0]     count;

  modport source (output valid, output token_value, output status, output is_summary,
                  output count, input ready);
  modport sink   (input valid, input token_value, input status, input is_summary,
                  input count, output ready);
endinterface

FILE: hdl/dilv_ram.sv
// generic single write port ram with registered read
module dilv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hdl/dilv_ctl.sv
// controller: input acceptance, duplicate search sequencing, result commit
module dilv_ctl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dilv_pkg::sts_t sts_i,
  output dilv_pkg::cmd_t cmd_o
);
  import dilv_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_SCAN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      CTL_SCAN: begin
        in_ready_o   = sts_i.out_free || !sts_i.needs_out;
        cmd_o.accept = in_valid_i && in_ready_o;
        if (cmd_o.accept && sts_i.to_search) begin
          state_d = CTL_SEARCH;
        end
      end
      CTL_SEARCH: begin
        cmd_o.search = 1'b1;
        if (sts_i.search_done && sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = CTL_SCAN;
        end
      end
      default: begin
        state_d = CTL_SCAN;
      end
    endcase
  end

endmodule

FILE: hdl/dilv_dp.sv
// datapath: token parser, value store, duplicate compare, output register
module dilv_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dilv_pkg::cmd_t                    cmd_i,
  output dilv_pkg::sts_t                    sts_o,
  input  logic [dilv_pkg::CH_W-1:0]         ch_i,
  input  logic                              end_list_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [dilv_pkg::VAL_W-1:0] token_value_o,
  output logic [1:0]                        status_o,
  output logic                              is_summary_o,
  output logic [dilv_pkg::COUNT_W-1:0]      count_o
);
  import dilv_pkg::*;

  phase_e             phase_q, phase_d;
  logic               neg_q, neg_d;
  logic [VAL_W-1:0]   mag_q, mag_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  status_e            ferr_q, ferr_d;
  logic               dup_q, dup_d;
  logic               pend_q, pend_d;

  logic               ovld_q, ovld_d;
  logic [VAL_W-1:0]   oval_q, oval_d;
  status_e            ost_q, ost_d;
  logic               osum_q, osum_d;
  logic [COUNT_W-1:0] ocnt_q, ocnt_d;

  logic [MAG_W-1:0]   next_mag;
  logic [MAG_W-1:0]   lim;
  logic               is_digit;
  logic               is_sign;
  logic               full;
  logic [VAL_W-1:0]   tok_val;
  status_e            fin_st;
  status_e            sum_st;
  logic               rd_en;
  logic               we;
  logic [VAL_W-1:0]   rdata;

  dilv_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (tok_val),
    .re_i    (rd_en),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  assign next_mag = ({4'b0000, mag_q} << 3) + ({4'b0000, mag_q} << 1)
                  + {{VAL_W{1'b0}}, ch_i[3:0]};
  assign lim      = neg_q ? NEG_LIM : POS_LIM;
  assign is_digit = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign is_sign  = (ch_i == CH_MINUS) || (ch_i == CH_PLUS);
  assign full     = cnt_q >= CNT_W'(MAX_COUNT);
  assign tok_val  = neg_q ? (VAL_W'(0) - mag_q) : mag_q;
  assign fin_st   = dup_q ? ST_DUP : (full ? ST_FULL : ST_OK);
  assign sum_st   = (ferr_q == ST_OK && phase_q != PH_START) ? ST_INVALID : ferr_q;
  assign rd_en    = cmd_i.search && !dup_q && (idx_q != cnt_q);
  assign we       = cmd_i.commit && !dup_q && !full;

  assign sts_o.needs_out   = end_list_i || (ch_i == CH_NUL);
  assign sts_o.to_search   = !end_list_i && (ch_i == CH_NUL) && (phase_q == PH_DIGITS);
  assign sts_o.search_done = dup_q || ((idx_q == cnt_q) && !pend_q);
  assign sts_o.out_free    = !ovld_q || out_ready_i;

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    ferr_d  = ferr_q;
    dup_d   = dup_q;
    pend_d  = rd_en;
    ovld_d  = ovld_q && !out_ready_i;
    oval_d  = oval_q;
    ost_d   = ost_q;
    osum_d  = osum_q;
    ocnt_d  = ocnt_q;

    if (rd_en) begin
      idx_d = idx_q + CNT_W'(1);
    end
    if (pend_q && (rdata == tok_val)) begin
      dup_d = 1'b1;
    end

    if (cmd_i.commit) begin
      if (we) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
      if (ferr_q == ST_OK) begin
        ferr_d = fin_st;
      end
      ovld_d  = 1'b1;
      oval_d  = tok_val;
      ost_d   = fin_st;
      osum_d  = 1'b0;
      ocnt_d  = COUNT_W'(cnt_d);
      phase_d = PH_START;
      neg_d   = 1'b0;
      mag_d   = '0;
    end

    if (cmd_i.accept) begin
      if (end_list_i) begin
        ovld_d  = 1'b1;
        oval_d  = '0;
        ost_d   = sum_st;
        osum_d  = 1'b1;
        ocnt_d  = COUNT_W'(cnt_q);
        phase_d = PH_START;
        neg_d   = 1'b0;
        mag_d   = '0;
        cnt_d   = '0;
        ferr_d  = ST_OK;
      end else if (ch_i != CH_NUL) begin
        if (phase_q != PH_BAD) begin
          if (is_digit) begin
            if (next_mag > lim) begin
              phase_d = PH_BAD;
            end else begin
              mag_d   = next_mag[VAL_W-1:0];
              phase_d = PH_DIGITS;
            end
          end else if (is_sign && phase_q == PH_START) begin
            neg_d   = (ch_i == CH_MINUS);
            phase_d = PH_SIGN;
          end else begin
            phase_d = PH_BAD;
          end
        end
      end else if (phase_q != PH_DIGITS) begin
        ovld_d  = 1'b1;
        oval_d  = '0;
        ost_d   = ST_INVALID;
        osum_d  = 1'b0;
        ocnt_d  = COUNT_W'(cnt_q);
        if (ferr_q == ST_OK) begin
          ferr_d = ST_INVALID;
        end
        phase_d = PH_START;
        neg_d   = 1'b0;
        mag_d   = '0;
      end else begin
        idx_d = '0;
        dup_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      ferr_q  <= ST_OK;
      dup_q   <= 1'b0;
      pend_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      ferr_q  <= ferr_d;
      dup_q   <= dup_d;
      pend_q  <= pend_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oval_q <= oval_d;
    ost_q  <= ost_d;
    osum_q <= osum_d;
    ocnt_q <= ocnt_d;
  end

  assign out_valid_o   = ovld_q;
  assign token_value_o = oval_q;
  assign status_o      = ost_q;
  assign is_summary_o  = osum_q;
  assign count_o       = ocnt_q;

endmodule

FILE: hdl/decimal_int_list_validator.sv
// top level of the decimal integer list validator
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   ch, end_list
//   out_o    out  valid/ready   token_value, status, is_summary, count
//
// plain characters are taken while no search runs, also while a result waits
// in the output register; zero bytes and end-of-list marks need room in out_o
// an empty, sign-only or bad token ends as its zero byte is taken, its result
// registered; a well-formed token is then compared with each stored value in
// turn, stopping early on a duplicate, and committed once out_o has room
// reset clears all control state; the value store needs no clearing
module decimal_int_list_validator (
  input logic        clk_i,
  input logic        rst_ni,
  dilv_in_if.sink    in_i,
  dilv_out_if.source out_o
);
  import dilv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dilv_ctl u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dilv_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .ch_i          (in_i.ch),
    .end_list_i    (in_i.end_list),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .token_value_o (out_o.token_value),
    .status_o      (out_o.status),
    .is_summary_o  (out_o.is_summary),
    .count_o       (out_o.count)
  );

`ifndef ASSERT_OFF
  a_commit_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !in_i.ready)
    else $error("input taken while a token result is committed");

  a_commit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> sts.out_free)
    else $error("result committed into an occupied output register");

  a_out_from_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.accept || cmd.commit))
    else $error("output item appeared without an accepted item or commit");
`endif

endmodule
